[src/bale_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bale_pkg: shared types and constants of the bounded array list engine
// Opcodes, status codes, cell commands and default sizes used by the top
// level, the storage cells and the port checker.
// ----------------------------------------------------------------------------
package bale_pkg;

  // Default geometry of the element store.
  localparam int DEPTH_DEFAULT = 64;
  localparam int WIDTH_DEFAULT = 32;

  // Fixed widths of the port fields.
  localparam int OPCODE_W = 3;
  localparam int POS_W    = 6;
  localparam int WORD_W   = 32;
  localparam int FILL_W   = 7;
  localparam int STATUS_W = 2;

  // Operation codes carried by an input word.
  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_READ   = 3'd4,
    OP_FIND   = 3'd5,
    OP_REMOVE = 3'd6
  } op_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // What every cell of the chain does in one cycle.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_INSERT,
    CELL_DELETE,
    CELL_SCAN
  } cell_op_t;

  // Command broadcast from the controller to all cells.
  typedef struct packed {
    cell_op_t op;
    logic     scan_wr;
  } cell_cmd_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

[src/bale_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bale_cell: one storage cell of the element chain
// Holds one list element. Every cycle it keeps its word, loads the broadcast
// word, or takes the word of its lower or upper neighbor, as decided by the
// broadcast command compared against its own fixed index.
// ----------------------------------------------------------------------------
module bale_cell #(
  parameter int WIDTH = bale_pkg::WIDTH_DEFAULT,
  parameter int CW    = 7,
  parameter int INDEX = 0
) (
  input  logic                clk,
  input  bale_pkg::cell_cmd_t cmd,
  input  logic [CW-1:0]       pos,
  input  logic [CW-1:0]       cnt,
  input  logic [CW-1:0]       wr_idx,
  input  logic [WIDTH-1:0]    wr_data,
  input  logic [WIDTH-1:0]    left_value,
  input  logic [WIDTH-1:0]    right_value,
  output logic [WIDTH-1:0]    value
);

  localparam logic [CW-1:0] IDX    = CW'(INDEX);
  localparam logic [CW-1:0] IDX_UP = CW'(INDEX + 1);

  logic [WIDTH-1:0] value_next;

  // Select the next word of this cell.
  always_comb begin
    value_next = value;
    unique case (cmd.op)
      bale_pkg::CELL_HOLD: begin
        value_next = value;
      end
      bale_pkg::CELL_PUSH: begin
        if (IDX == cnt) begin
          value_next = wr_data;
        end
      end
      bale_pkg::CELL_INSERT: begin
        // The new word lands at the position, everything above moves up.
        if (IDX == pos) begin
          value_next = wr_data;
        end else if ((IDX > pos) && (IDX <= cnt)) begin
          value_next = left_value;
        end
      end
      bale_pkg::CELL_DELETE: begin
        // Everything above the position moves down by one.
        if ((IDX >= pos) && (IDX_UP < cnt)) begin
          value_next = right_value;
        end
      end
      bale_pkg::CELL_SCAN: begin
        // The chain shifts toward cell zero; a kept head word re-enters here.
        if (cmd.scan_wr && (IDX == wr_idx)) begin
          value_next = wr_data;
        end else begin
          value_next = right_value;
        end
      end
      default: begin
        value_next = value;
      end
    endcase
  end

  // Element register; the store is undefined until written.
  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

[src/bounded_array_list_engine_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_array_list_engine_top: ordered list of words in a chain of cells
// Push, pop, insert, delete, read, find first and remove all on a list of
// up to DEPTH signed words, with one result word per input word.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall) takes one word: opcode, position
//   and operand_value. The output channel (out_valid, out_stall) returns one
//   word per input: data_value, found, found_position, fill_count, status.
//   Push, insert, delete, an out-of-range or full request, and the unused
//   opcode finish without a scan: the result is registered at the accepting
//   edge and a new word may follow in the next cycle.
//   Pop, read, find and remove rotate the whole chain of DEPTH cells once
//   through cell zero, where the controller reads, compares and drops
//   words, one per cycle, and registers the result as the rotation ends.
//   The output register parts the two channels: while out_stall is high the
//   result holds, and a new word is taken only once that result is leaving.
//   Reset clears the fill count, the controller state and the output valid
//   flag and stalls the input; the list is then empty and the element store
//   needs no clearing.
// ----------------------------------------------------------------------------
module bounded_array_list_engine_top #(
  parameter int DEPTH = bale_pkg::DEPTH_DEFAULT,
  parameter int WIDTH = bale_pkg::WIDTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bale_pkg::OPCODE_W-1:0]       opcode,
  input  logic [bale_pkg::POS_W-1:0]          position,
  input  logic signed [bale_pkg::WORD_W-1:0]  operand_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bale_pkg::WORD_W-1:0]  data_value,
  output logic                                found,
  output logic [bale_pkg::POS_W-1:0]          found_position,
  output logic [bale_pkg::FILL_W-1:0]         fill_count,
  output logic [bale_pkg::STATUS_W-1:0]       status
);

  // Count and index width: holds DEPTH itself and any input position.
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (CNT_W > bale_pkg::POS_W) ? CNT_W : bale_pkg::POS_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] LAST    = CW'(DEPTH - 1);
  localparam logic [CW-1:0] ONE     = CW'(1);

  // Controller state.
  bale_pkg::state_t state, state_next;
  bale_pkg::op_t    scan_op, scan_op_next;
  logic [CW-1:0]    count, count_next;
  logic [CW-1:0]    step, step_next;
  logic [CW-1:0]    removed, removed_next;
  logic [CW-1:0]    target, target_next;
  logic [WIDTH-1:0] key, key_next;
  logic             hit, hit_next;
  logic [CW-1:0]    hit_pos, hit_pos_next;
  logic [WIDTH-1:0] rd_data, rd_data_next;

  // Output register.
  logic                ovalid, ovalid_next;
  logic [WIDTH-1:0]    out_data, out_data_next;
  logic                out_found, out_found_next;
  logic [CW-1:0]       out_fpos, out_fpos_next;
  logic [CW-1:0]       out_count, out_count_next;
  bale_pkg::status_t   out_status, out_status_next;

  // Chain interface.
  bale_pkg::cell_cmd_t cmd;
  logic [CW-1:0]       wr_idx;
  logic [WIDTH-1:0]    wr_data;
  logic [WIDTH-1:0]    cell_value [DEPTH];

  // Decoded input word and scan helpers.
  bale_pkg::op_t    in_op;
  logic [CW-1:0]    pos_ext;
  logic [WIDTH-1:0] in_word;
  logic             accept;
  logic [WIDTH-1:0] head;
  logic             in_list;
  logic             drop;
  logic             is_read;
  logic [CW-1:0]    final_count;

  assign in_op   = bale_pkg::op_t'(opcode);
  assign pos_ext = CW'(position);
  assign in_word = WIDTH'(operand_value);

  // A new word is taken only out of reset, while idle and the output
  // register is free.
  assign in_stall = rst ||
                    !((state == bale_pkg::ST_IDLE) && (!ovalid || !out_stall));
  assign accept   = in_valid && !in_stall;

  // The head of the chain is what the scan looks at each cycle.
  assign head    = cell_value[0];
  assign in_list = step < count;
  assign is_read = (scan_op == bale_pkg::OP_POP) || (scan_op == bale_pkg::OP_READ);
  assign drop    = (scan_op == bale_pkg::OP_REMOVE) && in_list && (head == key);

  // Next state, cell command and result.
  always_comb begin
    state_next      = state;
    scan_op_next    = scan_op;
    count_next      = count;
    step_next       = step;
    removed_next    = removed;
    target_next     = target;
    key_next        = key;
    hit_next        = hit;
    hit_pos_next    = hit_pos;
    rd_data_next    = rd_data;
    ovalid_next     = ovalid && out_stall;
    out_data_next   = out_data;
    out_found_next  = out_found;
    out_fpos_next   = out_fpos;
    out_count_next  = out_count;
    out_status_next = out_status;
    cmd             = '{op: bale_pkg::CELL_HOLD, scan_wr: 1'b0};
    wr_idx          = '0;
    wr_data         = in_word;
    final_count     = count;

    unique case (state)
      bale_pkg::ST_IDLE: begin
        if (accept) begin
          // Default: an immediate result with the count unchanged.
          ovalid_next     = 1'b1;
          out_data_next   = '0;
          out_found_next  = 1'b0;
          out_fpos_next   = '0;
          out_count_next  = count;
          out_status_next = bale_pkg::STATUS_OK;

          // Setup for a rotation of the chain, used by the scanning ops.
          scan_op_next = in_op;
          step_next    = '0;
          removed_next = '0;
          target_next  = pos_ext;
          key_next     = in_word;
          hit_next     = 1'b0;
          hit_pos_next = '0;
          rd_data_next = '0;

          unique case (in_op)
            bale_pkg::OP_PUSH: begin
              if (count >= DEPTH_C) begin
                out_status_next = bale_pkg::STATUS_FULL;
              end else begin
                cmd            = '{op: bale_pkg::CELL_PUSH, scan_wr: 1'b0};
                count_next     = count + ONE;
                out_count_next = count + ONE;
              end
            end
            bale_pkg::OP_POP: begin
              if (count == '0) begin
                out_status_next = bale_pkg::STATUS_RANGE;
              end else begin
                target_next = count - ONE;
                ovalid_next = 1'b0;
                state_next  = bale_pkg::ST_SCAN;
              end
            end
            bale_pkg::OP_INSERT: begin
              if (pos_ext > count) begin
                out_status_next = bale_pkg::STATUS_RANGE;
              end else if (count >= DEPTH_C) begin
                out_status_next = bale_pkg::STATUS_FULL;
              end else begin
                cmd            = '{op: bale_pkg::CELL_INSERT, scan_wr: 1'b0};
                count_next     = count + ONE;
                out_count_next = count + ONE;
              end
            end
            bale_pkg::OP_DELETE: begin
              if (pos_ext >= count) begin
                out_status_next = bale_pkg::STATUS_RANGE;
              end else begin
                cmd            = '{op: bale_pkg::CELL_DELETE, scan_wr: 1'b0};
                count_next     = count - ONE;
                out_count_next = count - ONE;
              end
            end
            bale_pkg::OP_READ: begin
              if (pos_ext >= count) begin
                out_status_next = bale_pkg::STATUS_RANGE;
              end else begin
                ovalid_next = 1'b0;
                state_next  = bale_pkg::ST_SCAN;
              end
            end
            bale_pkg::OP_FIND, bale_pkg::OP_REMOVE: begin
              ovalid_next = 1'b0;
              state_next  = bale_pkg::ST_SCAN;
            end
            default: begin
              // Unused opcode: no change, count reported.
              out_status_next = bale_pkg::STATUS_OK;
            end
          endcase
        end
      end

      bale_pkg::ST_SCAN: begin
        // Shift the chain down; a kept head word goes back in above the
        // words already kept, which compacts the list as it rotates.
        cmd     = '{op: bale_pkg::CELL_SCAN, scan_wr: in_list && !drop};
        wr_idx  = LAST - removed;
        wr_data = head;

        if (is_read && (step == target)) begin
          rd_data_next = head;
        end
        if ((scan_op == bale_pkg::OP_FIND) && in_list && !hit && (head == key)) begin
          hit_next     = 1'b1;
          hit_pos_next = step;
        end
        removed_next = removed + CW'(drop);
        step_next    = step + ONE;

        // The last step puts every word back in place and ends the item.
        if (step == LAST) begin
          if (scan_op == bale_pkg::OP_REMOVE) begin
            final_count = count - removed_next;
          end else if (scan_op == bale_pkg::OP_POP) begin
            final_count = count - ONE;
          end else begin
            final_count = count;
          end
          count_next      = final_count;
          state_next      = bale_pkg::ST_IDLE;
          ovalid_next     = 1'b1;
          out_data_next   = rd_data_next;
          out_found_next  = hit_next;
          out_fpos_next   = hit_pos_next;
          out_count_next  = final_count;
          out_status_next = bale_pkg::STATUS_OK;
        end
      end

      default: begin
        state_next = bale_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= bale_pkg::ST_IDLE;
      count  <= '0;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      ovalid <= ovalid_next;
    end
  end

  // Scan and result payload registers.
  always_ff @(posedge clk) begin
    scan_op    <= scan_op_next;
    step       <= step_next;
    removed    <= removed_next;
    target     <= target_next;
    key        <= key_next;
    hit        <= hit_next;
    hit_pos    <= hit_pos_next;
    rd_data    <= rd_data_next;
    out_data   <= out_data_next;
    out_found  <= out_found_next;
    out_fpos   <= out_fpos_next;
    out_count  <= out_count_next;
    out_status <= out_status_next;
  end

  // Row of element cells, each wired to its two neighbors.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int LEFT  = (i == 0) ? 0 : i - 1;
    localparam int RIGHT = (i == DEPTH - 1) ? i : i + 1;

    bale_cell #(
      .WIDTH (WIDTH),
      .CW    (CW),
      .INDEX (i)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .pos         (pos_ext),
      .cnt         (count),
      .wr_idx      (wr_idx),
      .wr_data     (wr_data),
      .left_value  (cell_value[LEFT]),
      .right_value (cell_value[RIGHT]),
      .value       (cell_value[i])
    );
  end

  // Result word on the output ports.
  assign out_valid      = ovalid;
  assign data_value     = bale_pkg::WORD_W'($signed(out_data));
  assign found          = out_found;
  assign found_position = bale_pkg::POS_W'(out_fpos);
  assign fill_count     = bale_pkg::FILL_W'(out_count);
  assign status         = out_status;

endmodule

[src/bale_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bale_checker: port-level checks of the bounded array list engine
// Watches the top level's ports and flags results that break the rules of
// the list: held words, count bounds and status consistency.
// ----------------------------------------------------------------------------
module bale_checker #(
  parameter int DEPTH = bale_pkg::DEPTH_DEFAULT
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [bale_pkg::WORD_W-1:0]  data_value,
  input logic                                found,
  input logic [bale_pkg::POS_W-1:0]          found_position,
  input logic [bale_pkg::FILL_W-1:0]         fill_count,
  input logic [bale_pkg::STATUS_W-1:0]       status
);

  // A stalled result word holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_value) && $stable(found)
      && $stable(found_position) && $stable(fill_count) && $stable(status))
    else $error("result word changed while stalled");

  // No result is pending right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // The reported count never exceeds the store.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (DEPTH > 127) || (int'(fill_count) <= DEPTH))
    else $error("fill count above store depth");

  // A full report comes only from a full store.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == bale_pkg::STATUS_FULL)
      |-> (DEPTH > 127) || (int'(fill_count) == DEPTH))
    else $error("store full reported with room left");

  // A failed request returns no data and no match.
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != bale_pkg::STATUS_OK) |-> (data_value == '0) && !found)
    else $error("failed request carries data");

endmodule

bind bounded_array_list_engine_top bale_checker #(.DEPTH(DEPTH)) u_bale_checker (.*);

[dv/bounded_array_list_engine_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_array_list_engine_top_tb: self-checking bench for the list engine
// Drives list operations through the valid/stall input channel and keeps a
// shadow list that predicts every result word. Covers the empty-list,
// out-of-range and full-store cases by directed words, then a long random
// mix that grows the list to capacity and shrinks it again, under random
// sender bursts, receiver stall patterns and a long receiver hold-off.
// ----------------------------------------------------------------------------
module bounded_array_list_engine_top_tb;
  import bale_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEFAULT;
  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_WORDS = 1650;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;

  // Expected content of one result word.
  typedef struct {
    logic signed [WORD_W-1:0] data;
    logic                     hit;
    logic [POS_W-1:0]         hit_pos;
    logic [FILL_W-1:0]        fill;
    logic [STATUS_W-1:0]      st;
  } list_result_t;

  typedef enum int {RX_FREE, RX_PATTERN, RX_HEAVY} rx_mode_t;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic [OPCODE_W-1:0]        opcode;
  logic [POS_W-1:0]           position;
  logic signed [WORD_W-1:0]   operand_value;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [WORD_W-1:0]   data_value;
  logic                       found;
  logic [POS_W-1:0]           found_position;
  logic [FILL_W-1:0]          fill_count;
  logic [STATUS_W-1:0]        status;

  // Shadow copy of the list and the results still owed by the block.
  logic signed [WORD_W-1:0]   shadow_list [LIST_DEPTH];
  int unsigned                shadow_count;
  list_result_t               pending_results [$];
  list_result_t               want_result;

  // Run statistics.
  int error_count;
  int words_sent;
  int results_checked;
  int full_hits;
  int range_hits;
  int find_hits;
  int idle_cycles;

  // Sender and receiver pacing controls.
  bit       sender_gaps;
  int       burst_left;
  rx_mode_t rx_mode;
  int       hold_request;
  int       hold_left;
  bit       run_stalled;
  int       run_left;

  bounded_array_list_engine_top #(
    .DEPTH(LIST_DEPTH),
    .WIDTH(WIDTH_DEFAULT)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .position      (position),
    .operand_value (operand_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .data_value    (data_value),
    .found         (found),
    .found_position(found_position),
    .fill_count    (fill_count),
    .status        (status)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one operation to the shadow list and return the result it owes.
  function automatic list_result_t apply_list_op(input logic [OPCODE_W-1:0] op,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic signed [WORD_W-1:0] val);
    list_result_t r;
    int unsigned  i;
    int unsigned  kept;
    r.data = '0;
    r.hit = 1'b0;
    r.hit_pos = '0;
    r.st = STATUS_OK;
    case (op)
      OP_PUSH: begin
        if (shadow_count >= LIST_DEPTH) begin
          r.st = STATUS_FULL;
        end else begin
          shadow_list[shadow_count] = val;
          shadow_count++;
        end
      end
      OP_POP: begin
        if (shadow_count == 0) begin
          r.st = STATUS_RANGE;
        end else begin
          r.data = shadow_list[shadow_count-1];
          shadow_count--;
        end
      end
      OP_INSERT: begin
        // Range is checked before capacity; inserting at the count appends.
        if (pos > shadow_count) begin
          r.st = STATUS_RANGE;
        end else if (shadow_count >= LIST_DEPTH) begin
          r.st = STATUS_FULL;
        end else begin
          for (i = shadow_count; i > pos; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[pos] = val;
          shadow_count++;
        end
      end
      OP_DELETE: begin
        if (pos >= shadow_count) begin
          r.st = STATUS_RANGE;
        end else begin
          for (i = pos; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
          shadow_count--;
        end
      end
      OP_READ: begin
        if (pos >= shadow_count) begin
          r.st = STATUS_RANGE;
        end else begin
          r.data = shadow_list[pos];
        end
      end
      OP_FIND: begin
        for (i = 0; i < shadow_count; i++) begin
          if (!r.hit && shadow_list[i] == val) begin
            r.hit = 1'b1;
            r.hit_pos = i[POS_W-1:0];
          end
        end
      end
      OP_REMOVE: begin
        // Compact the survivors toward the head, keeping their order.
        kept = 0;
        for (i = 0; i < shadow_count; i++) begin
          if (shadow_list[i] != val) begin
            shadow_list[kept] = shadow_list[i];
            kept++;
          end
        end
        shadow_count = kept;
      end
      default: begin
      end
    endcase
    r.fill = shadow_count[FILL_W-1:0];
    return r;
  endfunction

  // Print one failure line and count it.
  task automatic report_error(input string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] got,
                             input logic [WORD_W-1:0] want);
    if (got !== want)
      report_error($sformatf("%s mismatch: got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // Offer one word, wait for it to be taken, then record its prediction.
  task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic signed [WORD_W-1:0] val);
    list_result_t r;
    int           gap;
    if (sender_gaps) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 70) : $urandom_range(1, 8);
        repeat (gap) begin
          @(negedge clk);
          in_valid = 1'b0;
        end
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    @(negedge clk);
    in_valid = 1'b1;
    opcode = op;
    position = pos;
    operand_value = val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = apply_list_op(op, pos, val);
    if (r.st == STATUS_FULL) full_hits++;
    if (r.st == STATUS_RANGE) range_hits++;
    if (r.hit) find_hits++;
    pending_results.push_back(r);
    words_sent++;
  endtask

  // Stop offering and wait until every owed result has come back.
  task automatic pause_until_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Operand values: a small pool so finds and removes hit, or any value.
  function automatic logic signed [WORD_W-1:0] pick_value();
    logic signed [WORD_W-1:0] pool [8];
    pool = '{32'sd0, 32'sd1, -32'sd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'sd5, 32'sd42,
             -32'sd42};
    if ($urandom_range(0, 3) < 2) return pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // Positions: mostly near the live range, sometimes anywhere.
  function automatic logic [POS_W-1:0] pick_position();
    int unsigned top;
    top = (shadow_count > 63) ? 63 : shadow_count;
    if ($urandom_range(0, 4) == 0) return POS_W'($urandom_range(0, 63));
    return POS_W'($urandom_range(0, top));
  endfunction

  // Operation mix that favors growth or shrinkage.
  function automatic logic [OPCODE_W-1:0] pick_op(input bit growing);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return OP_UNUSED;
    if (growing) begin
      if (r < 32) return OP_PUSH;
      if (r < 55) return OP_INSERT;
      if (r < 62) return OP_POP;
      if (r < 69) return OP_DELETE;
      if (r < 80) return OP_READ;
      if (r < 92) return OP_FIND;
      return OP_REMOVE;
    end
    if (r < 12) return OP_PUSH;
    if (r < 20) return OP_INSERT;
    if (r < 42) return OP_POP;
    if (r < 64) return OP_DELETE;
    if (r < 76) return OP_READ;
    if (r < 88) return OP_FIND;
    return OP_REMOVE;
  endfunction

  // Pop, read, delete, find, remove and an insert past the end on an empty list.
  task automatic test_empty_list();
    send_word(OP_POP, 6'd0, 32'sd0);
    send_word(OP_READ, 6'd0, 32'sd0);
    send_word(OP_DELETE, 6'd0, 32'sd0);
    send_word(OP_FIND, 6'd0, 32'sd0);
    send_word(OP_REMOVE, 6'd0, -32'sd1);
    send_word(OP_INSERT, 6'd1, 32'sd9);
  endtask

  // Extreme values, inserts at both ends, reads, finds, deletes, the unused
  // opcode and a remove of repeated values.
  task automatic test_basic_ops();
    send_word(OP_PUSH, 6'd0, 32'h7FFF_FFFF);
    send_word(OP_PUSH, 6'd63, 32'h8000_0000);
    send_word(OP_INSERT, 6'd0, -32'sd1);
    send_word(OP_INSERT, 6'd3, 32'sd0);
    send_word(OP_READ, 6'd63, 32'sd0);
    send_word(OP_READ, 6'd2, 32'sd0);
    send_word(OP_FIND, 6'd0, 32'h8000_0000);
    send_word(OP_FIND, 6'd0, 32'sd12345);
    send_word(OP_DELETE, 6'd1, 32'sd0);
    send_word(OP_UNUSED, 6'd5, 32'sd77);
    send_word(OP_PUSH, 6'd0, -32'sd1);
    send_word(OP_REMOVE, 6'd0, -32'sd1);
    send_word(OP_DELETE, 6'd40, 32'sd0);
    send_word(OP_POP, 6'd0, 32'sd0);
    send_word(OP_POP, 6'd0, 32'sd0);
  endtask

  // Fill to capacity, hit the full cases, work the top entry, then remove
  // the repeated fill values so that only the inserted word is left.
  task automatic test_full_store();
    logic signed [WORD_W-1:0] fill_vals [3];
    fill_vals = '{32'sd7, -32'sd7, 32'h5555_5555};
    while (shadow_count < LIST_DEPTH) send_word(OP_PUSH, 6'd0, fill_vals[$urandom_range(0, 2)]);
    send_word(OP_PUSH, 6'd0, 32'sd1);
    send_word(OP_INSERT, 6'd10, 32'sd1);
    send_word(OP_INSERT, 6'd63, 32'sd1);
    send_word(OP_READ, 6'd63, 32'sd0);
    send_word(OP_FIND, 6'd0, 32'h5555_5555);
    send_word(OP_DELETE, 6'd63, 32'sd0);
    send_word(OP_INSERT, 6'd63, 32'sd3);
    send_word(OP_FIND, 6'd0, 32'sd3);
    send_word(OP_REMOVE, 6'd0, 32'sd7);
    send_word(OP_REMOVE, 6'd0, -32'sd7);
    send_word(OP_REMOVE, 6'd0, 32'h5555_5555);
    send_word(OP_READ, 6'd0, 32'sd0);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // so the output register fills and the input stalls; then drain fully.
  task automatic test_backpressure();
    int k;
    sender_gaps = 1'b0;
    rx_mode = RX_FREE;
    hold_request = 300;
    for (k = 0; k < 24; k++) send_word(pick_op(1'b1), pick_position(), pick_value());
    pause_until_drained();
    sender_gaps = 1'b1;
  endtask

  // Long random mix; the list swings between empty and full.
  task automatic test_random_mix(input int count);
    int k;
    bit growing;
    growing = 1'b1;
    for (k = 0; k < count; k++) begin
      // Change pacing every 200 words, with some stretches at full rate.
      if (k % 200 == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        sender_gaps = ($urandom_range(0, 3) != 0);
      end
      if (shadow_count == 0) growing = 1'b1;
      if (shadow_count == LIST_DEPTH && $urandom_range(0, 3) == 0) growing = 1'b0;
      send_word(pick_op(growing), pick_position(), pick_value());
    end
  endtask

  // Receiver stall pattern and long hold-off, counted here.
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    run_left = 0;
    run_stalled = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (rx_mode == RX_FREE) begin
        out_stall = 1'b0;
      end else begin
        if (run_left == 0) begin
          run_stalled = !run_stalled;
          if (rx_mode == RX_HEAVY)
            run_left = run_stalled ? $urandom_range(2, 12) : $urandom_range(1, 3);
          else
            run_left = run_stalled ? $urandom_range(1, 3) : $urandom_range(1, 8);
        end
        run_left--;
        out_stall = run_stalled;
      end
    end
  end

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_error("result word arrived with nothing expected");
      end else begin
        want_result = pending_results.pop_front();
        check_field("data_value", data_value, want_result.data);
        check_field("found", WORD_W'(found), WORD_W'(want_result.hit));
        check_field("found_position", WORD_W'(found_position),
                    WORD_W'(want_result.hit_pos));
        check_field("fill_count", WORD_W'(fill_count), WORD_W'(want_result.fill));
        check_field("status", WORD_W'(status), WORD_W'(want_result.st));
        results_checked++;
      end
    end
  end

  // Watchdog: end the run if no word moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no word accepted for %0d cycles", IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = '0;
    position = '0;
    operand_value = '0;
    shadow_count = 0;
    error_count = 0;
    words_sent = 0;
    results_checked = 0;
    full_hits = 0;
    range_hits = 0;
    find_hits = 0;
    idle_cycles = 0;
    sender_gaps = 1'b1;
    burst_left = 0;
    rx_mode = RX_PATTERN;
    hold_request = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_list();
    test_basic_ops();
    pause_until_drained();
    test_full_store();
    test_backpressure();
    test_random_mix(RANDOM_WORDS);

    // Let the last result drain, then allow the block's full latency.
    pause_until_drained();
    repeat (LIST_DEPTH + 10) @(posedge clk);
    if (pending_results.size() != 0)
      report_error($sformatf("%0d result words never arrived", pending_results.size()));

    $display("Sent %0d words, checked %0d results; list ran from empty to full and back.",
             words_sent, results_checked);
    $display("Full-store results %0d, range results %0d, successful finds %0d.",
             full_hits, range_hits, find_hits);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
src/bale_pkg.sv
src/bale_cell.sv
src/bounded_array_list_engine_top.sv
src/bale_checker.sv
dv/bounded_array_list_engine_top_tb.sv
